/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk and disabled while rst is high
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/bmwb_pkg.sv */
// ----------------------------------------------------------------------------
// bmwb_pkg
// shared types and constants of the bitmap window blit
// ----------------------------------------------------------------------------
package bmwb_pkg;

  // register indexes
  localparam logic [1:0] REG_COLUMN_START = 2'd0;
  localparam logic [1:0] REG_ROW_START    = 2'd1;
  localparam logic [1:0] REG_PIXEL_WIDTH  = 2'd2;
  localparam logic [1:0] REG_ROW_COUNT    = 2'd3;

  localparam logic [7:0] COL_OFFSET = 8'h25;

  // sequence positions inside one request
  localparam logic [4:0] HDR_FIRST  = 5'd0;
  localparam logic [4:0] DATA_FIRST = 5'd13;
  localparam logic [4:0] DATA_LAST  = 5'd16;

  typedef struct packed {
    logic [7:0] column_start;
    logic [7:0] row_start;
    logic [7:0] pixel_width;
    logic [7:0] row_count;
    logic [6:0] width_div3;
    logic [1:0] width_mod3;
  } cfg_t;

  // one classified request for the back sequencer
  typedef struct packed {
    logic       hdr;
    logic [7:0] bits;
    logic [1:0] pad;
  } desc_t;

  typedef struct packed {
    logic not_full;
    logic not_empty;
  } fifo_stat_t;

endpackage

/* rtl/bmwb_if.sv */
// ----------------------------------------------------------------------------
// bmwb channel interfaces
// valid/ready channels for bitmap bytes in and bus writes out
// ----------------------------------------------------------------------------
interface bmwb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] bitmap_byte;

  modport source (output valid, output bitmap_byte, input ready);
  modport sink (input valid, input bitmap_byte, output ready);
endinterface

interface bmwb_out_if;
  logic       valid;
  logic       ready;
  logic       is_data;
  logic [7:0] bus_byte;
  logic       last;

  modport source (output valid, output is_data, output bus_byte, output last, input ready);
  modport sink (input valid, input is_data, input bus_byte, input last, output ready);
endinterface

/* rtl/bmwb_front.sv */
// ----------------------------------------------------------------------------
// bmwb_front
// accepts bitmap bytes, tracks row and picture position, classifies requests
// ----------------------------------------------------------------------------
module bmwb_front
  import bmwb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  bmwb_in_if.sink    in_ch,
  input  fifo_stat_t fstat,
  output logic       push,
  output desc_t      desc
);

  logic       header_sent;
  logic [4:0] byte_in_row;
  logic [7:0] rows_done;

  logic [4:0] bpr;
  logic [4:0] cur_byte;
  logic [7:0] cur_rows;
  logic       row_end;
  logic       pic_end;

  assign in_ch.ready = fstat.not_full;
  assign push        = in_ch.valid && fstat.not_full;

  always_comb begin
    bpr = cfg.pixel_width[7:3];
    if (bpr == 5'd0) begin
      bpr = 5'd1;
    end
    // a pending header restarts the picture position
    cur_byte = header_sent ? byte_in_row : 5'd0;
    cur_rows = header_sent ? rows_done : 8'd0;
    row_end  = ({1'b0, cur_byte} + 6'd1) >= {1'b0, bpr};
    pic_end  = ({1'b0, cur_rows} + 9'd1) >= {1'b0, cfg.row_count};
    desc.hdr  = !header_sent;
    desc.bits = in_ch.bitmap_byte;
    desc.pad  = row_end ? cfg.width_mod3 : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_sent <= 1'b0;
      byte_in_row <= 5'd0;
      rows_done   <= 8'd0;
    end else if (push) begin
      if (row_end) begin
        byte_in_row <= 5'd0;
        if (pic_end) begin
          rows_done   <= 8'd0;
          header_sent <= 1'b0;
        end else begin
          rows_done   <= cur_rows + 8'd1;
          header_sent <= 1'b1;
        end
      end else begin
        byte_in_row <= cur_byte + 5'd1;
        rows_done   <= cur_rows;
        header_sent <= 1'b1;
      end
    end
  end

endmodule

/* rtl/bmwb_fifo.sv */
// ----------------------------------------------------------------------------
// bmwb_fifo
// short request queue between front and back
// ----------------------------------------------------------------------------
module bmwb_fifo
  import bmwb_pkg::*;
#(
  parameter int DEPTH = 2
)
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  desc_t      din,
  input  logic       pop,
  output desc_t      dout,
  output fifo_stat_t fstat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  desc_t         slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign fstat.not_full  = count != CW'(DEPTH);
  assign fstat.not_empty = count != CW'(0);
  assign dout            = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

/* rtl/bmwb_back.sv */
// ----------------------------------------------------------------------------
// bmwb_back
// sequences header, pixel-pair data and pad writes of each request
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bmwb_back
  import bmwb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  fifo_stat_t fstat,
  input  desc_t      fdata,
  output logic       pop,
  bmwb_out_if.source out_ch
);

  // header positions
  localparam logic [4:0] H_WIN_X_CMD = 5'd0;
  localparam logic [4:0] H_WIN_X     = 5'd1;
  localparam logic [4:0] H_WIN_Y_CMD = 5'd2;
  localparam logic [4:0] H_WIN_Y     = 5'd3;
  localparam logic [4:0] H_WIN_W_CMD = 5'd4;
  localparam logic [4:0] H_WIN_W     = 5'd5;
  localparam logic [4:0] H_WIN_H_CMD = 5'd6;
  localparam logic [4:0] H_WIN_H     = 5'd7;
  localparam logic [4:0] H_WIN_MODE  = 5'd8;
  localparam logic [4:0] H_COL_LO    = 5'd9;
  localparam logic [4:0] H_COL_HI    = 5'd10;
  localparam logic [4:0] H_ROW_LO    = 5'd11;
  localparam logic [4:0] H_ROW_HI    = 5'd12;

  localparam logic [7:0] CMD_WIN_X  = 8'hf4;
  localparam logic [7:0] CMD_WIN_Y  = 8'hf5;
  localparam logic [7:0] CMD_WIN_W  = 8'hf6;
  localparam logic [7:0] CMD_WIN_H  = 8'hf7;
  localparam logic [7:0] CMD_WIN_EN = 8'hf8;
  localparam logic [7:0] CMD_COL_HI = 8'h10;
  localparam logic [7:0] CMD_ROW_LO = 8'h60;
  localparam logic [7:0] CMD_ROW_HI = 8'h70;

  localparam logic [7:0] PAIR_MAP [4] = '{8'h00, 8'h0f, 8'hf0, 8'hff};

  logic       busy;
  desc_t      cur;
  logic [4:0] step;
  logic [4:0] end_step;
  logic       at_end;
  logic       produce;
  logic       load;
  logic [7:0] cx;
  logic [1:0] pair_idx;
  logic [1:0] pair;
  logic [4:0] data_off;
  logic [7:0] next_byte;

  assign end_step = DATA_LAST + {3'd0, cur.pad};
  assign at_end   = step == end_step;
  assign produce  = busy && (!out_ch.valid || out_ch.ready);
  assign load     = fstat.not_empty && (!busy || (produce && at_end));
  assign pop      = load;
  assign cx       = cfg.column_start + COL_OFFSET;
  assign data_off = step - DATA_FIRST;
  assign pair_idx = data_off[1:0];

  always_comb begin
    case (pair_idx)
      2'd0:    pair = cur.bits[7:6];
      2'd1:    pair = cur.bits[5:4];
      2'd2:    pair = cur.bits[3:2];
      default: pair = cur.bits[1:0];
    endcase
  end

  always_comb begin
    unique case (step)
      H_WIN_X_CMD: next_byte = CMD_WIN_X;
      H_WIN_X:     next_byte = cx;
      H_WIN_Y_CMD: next_byte = CMD_WIN_Y;
      H_WIN_Y:     next_byte = cfg.row_start;
      H_WIN_W_CMD: next_byte = CMD_WIN_W;
      H_WIN_W:     next_byte = COL_OFFSET + {1'b0, cfg.width_div3};
      H_WIN_H_CMD: next_byte = CMD_WIN_H;
      H_WIN_H:     next_byte = cfg.row_count - 8'd1;
      H_WIN_MODE:  next_byte = CMD_WIN_EN;
      H_COL_LO:    next_byte = {4'd0, cx[3:0]};
      H_COL_HI:    next_byte = CMD_COL_HI | {4'd0, cx[7:4]};
      H_ROW_LO:    next_byte = CMD_ROW_LO + {4'd0, cfg.row_start[3:0]};
      H_ROW_HI:    next_byte = CMD_ROW_HI + {4'd0, cfg.row_start[7:4]};
      default: begin
        // data positions map pixel pairs, positions past the data are pad
        next_byte = (step <= DATA_LAST) ? PAIR_MAP[pair] : 8'h00;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      if (produce) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
      if (load) begin
        busy <= 1'b1;
      end else if (produce && at_end) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur  <= fdata;
      step <= fdata.hdr ? HDR_FIRST : DATA_FIRST;
    end else if (produce) begin
      step <= step + 5'd1;
    end
    if (produce) begin
      out_ch.is_data  <= step >= DATA_FIRST;
      out_ch.bus_byte <= next_byte;
      out_ch.last     <= at_end;
    end
  end

  `ASSERT_IMPL(a_last_is_data, clk, rst, out_ch.valid && out_ch.last, out_ch.is_data)
  `ASSERT_IMPL(a_step_in_range, clk, rst, busy, step <= end_step)
  `ASSERT_IMPL(a_hdr_only_flagged, clk, rst, busy && (step < DATA_FIRST), cur.hdr)

endmodule

/* rtl/mono_bitmap_window_blit_core.sv */
// ----------------------------------------------------------------------------
// mono_bitmap_window_blit_core
// bitmap byte stream to display controller command and data write sequence
// ----------------------------------------------------------------------------
// Each accepted bitmap byte becomes four data writes (one per 2-bit pixel
// pair, msb pair first, mapped to 00/0f/f0/ff), followed by pixel_width%3
// zero pad writes when it closes a row. The first byte of a picture is
// preceded by thirteen command writes (window setup and cursor address).
// The back sequencer emits one bus write per cycle through its output
// register while the output is not stalled. The front keeps accepting bytes
// into a short request queue while the back drains, so a stalled output does
// not block intake until the queue is full. Registers live on an apb-style
// port at byte addresses 0, 4, 8, 12; the user must write them only while the
// block is idle, and the block itself does not enforce it.
// ----------------------------------------------------------------------------
module mono_bitmap_window_blit_core
  import bmwb_pkg::*;
#(
  parameter int FIFO_DEPTH = 2  // request queue depth, 2 or more
)
(
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // bitmap byte requests in
  bmwb_in_if.sink     in_ch,
  // bus write requests out
  bmwb_out_if.source  out_ch
);

  // configuration registers
  logic [7:0]  column_start;
  logic [7:0]  row_start;
  logic [7:0]  pixel_width;
  logic [7:0]  row_count;

  logic [1:0]  reg_idx;
  logic        wr_en;
  logic [15:0] div_prod;
  logic [6:0]  div3;
  logic [7:0]  mod3_full;
  cfg_t        cfg;

  desc_t       push_desc;
  desc_t       pop_desc;
  logic        push;
  logic        pop;
  fifo_stat_t  fstat;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_start <= 8'd0;
      row_start    <= 8'd0;
      pixel_width  <= 8'd8;
      row_count    <= 8'd1;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_COLUMN_START: column_start <= pwdata[7:0];
        REG_ROW_START:    row_start    <= pwdata[7:0];
        REG_PIXEL_WIDTH:  pixel_width  <= pwdata[7:0];
        REG_ROW_COUNT:    row_count    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (reg_idx)
      REG_COLUMN_START: prdata = {24'd0, column_start};
      REG_ROW_START:    prdata = {24'd0, row_start};
      REG_PIXEL_WIDTH:  prdata = {24'd0, pixel_width};
      REG_ROW_COUNT:    prdata = {24'd0, row_count};
      default:          prdata = 32'd0;
    endcase
  end

  // width / 3 by reciprocal: (w * 171) >> 9 is exact for 8-bit w
  assign div_prod  = {8'd0, pixel_width} * 16'd171;
  assign div3      = div_prod[15:9];
  assign mod3_full = pixel_width - ({div3, 1'b0} + {1'b0, div3});

  always_comb begin
    cfg.column_start = column_start;
    cfg.row_start    = row_start;
    cfg.pixel_width  = pixel_width;
    cfg.row_count    = row_count;
    cfg.width_div3   = div3;
    cfg.width_mod3   = mod3_full[1:0];
  end

  // front: intake and row / picture tracking
  bmwb_front u_front (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .in_ch (in_ch),
    .fstat (fstat),
    .push  (push),
    .desc  (push_desc)
  );

  // request queue
  bmwb_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (push_desc),
    .pop   (pop),
    .dout  (pop_desc),
    .fstat (fstat)
  );

  // back: write sequencer with output register
  bmwb_back u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .fstat  (fstat),
    .fdata  (pop_desc),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule
